// ===== hdl/rectangle_sum_table_unit_assert.svh =====
// Assertion macros for the rectangle sum table unit.
`ifndef RECTANGLE_SUM_TABLE_UNIT_ASSERT_SVH
`define RECTANGLE_SUM_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSUMT_ASSERT(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define RSUMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RSUMT_ASSERT(label, clk, rst_n, expr, msg)
`define RSUMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/rsumt_pkg.sv =====
// Types and constants shared by the rectangle sum table unit.
package rsumt_pkg;

	localparam int SUM_W = 33;
	localparam int POS_W = 9;
	localparam int CFG_W = 9;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 1'd1;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_COORD  = 2'd1,
		STATUS_NOT_LOADED = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] element_value;
		logic [7:0]         top_row;
		logic [7:0]         left_col;
		logic [7:0]         bottom_row;
		logic [7:0]         right_col;
	} request_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] rect_sum;
		status_t                 status;
	} result_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_QUERY,
		CMD_ERROR
	} cmd_kind_t;

	// Up to four table terms are formed from two rows and two columns.
	// A load writes at (hi_row, hi_col) and reads the entry at (lo_row, hi_col).
	typedef struct packed {
		cmd_kind_t kind;
		status_t   status;
		sum_t      sum;
		pos_t      hi_row;
		pos_t      hi_col;
		pos_t      lo_row;
		pos_t      lo_col;
		logic      use_lo_row;
		logic      use_lo_col;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LREAD,
		B_LWRITE,
		B_QREAD,
		B_QLAST,
		B_EMIT
	} back_state_t;

endpackage

// ===== hdl/rsumt_queue.sv =====
// Small first-in first-out queue with push/full and pop/empty sides.
module rsumt_queue #(
	parameter int  DEPTH  = 2,
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t wr_item,
	input  logic  pop,
	output logic  empty,
	output item_t rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/rsumt_front.sv =====
// Front end: tracks the load position and sizes, checks queries, forms commands.
module rsumt_front #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  rsumt_pkg::request_t                    req,
	input  logic                                   cfg_write,
	input  logic [rsumt_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rsumt_pkg::CFG_W-1:0]            cfg_data,
	output rsumt_pkg::cmd_t                        cmd
);
	import rsumt_pkg::*;

	localparam pos_t ROWS_CAP   = (MAX_ROWS > 511) ? 9'd511 : 9'(MAX_ROWS);
	localparam pos_t COLS_CAP   = (MAX_COLS > 511) ? 9'd511 : 9'(MAX_COLS);
	localparam pos_t ROWS_RESET = (ROWS_CAP < 9'd256) ? ROWS_CAP : 9'd256;
	localparam pos_t COLS_RESET = (COLS_CAP < 9'd256) ? COLS_CAP : 9'd256;

	pos_t rows_q;
	pos_t cols_q;
	pos_t row_q;
	pos_t col_q;
	sum_t run_q;
	logic loaded_q;

	sum_t elem_ext;
	sum_t run_d;
	pos_t row_d;
	pos_t col_d;
	pos_t col_inc;
	pos_t row_inc;
	logic loaded_d;
	logic bad_coord;

	function automatic pos_t clamp_size(pos_t v, pos_t cap);
		if (v == '0) begin
			return 9'd1;
		end
		if (v > cap) begin
			return cap;
		end
		return v;
	endfunction

	assign elem_ext = {{(SUM_W - 16){req.element_value[15]}}, req.element_value};
	assign col_inc  = col_q + 1'b1;
	assign row_inc  = row_q + 1'b1;
	assign bad_coord = (req.top_row > req.bottom_row) || (req.left_col > req.right_col)
		|| ({1'b0, req.bottom_row} >= rows_q) || ({1'b0, req.right_col} >= cols_q);

	always_comb begin
		run_d    = (col_q == '0) ? elem_ext : run_q + elem_ext;
		row_d    = row_q;
		col_d    = col_inc;
		// A load at the origin begins a new matrix.
		loaded_d = (row_q == '0 && col_q == '0) ? 1'b0 : loaded_q;
		if (col_inc >= cols_q) begin
			col_d = '0;
			row_d = row_inc;
			if (row_inc >= rows_q) begin
				row_d    = '0;
				loaded_d = 1'b1;
			end
		end
	end

	always_comb begin
		cmd = '0;
		if (req.op == OP_LOAD) begin
			cmd.kind       = CMD_LOAD;
			cmd.status     = STATUS_OK;
			cmd.sum        = run_d;
			cmd.hi_row     = row_q;
			cmd.hi_col     = col_q;
			cmd.lo_row     = row_q - 1'b1;
			cmd.use_lo_row = (row_q != '0);
		end else begin
			cmd.hi_row     = {1'b0, req.bottom_row};
			cmd.hi_col     = {1'b0, req.right_col};
			cmd.lo_row     = {1'b0, req.top_row} - 1'b1;
			cmd.lo_col     = {1'b0, req.left_col} - 1'b1;
			cmd.use_lo_row = (req.top_row != '0);
			cmd.use_lo_col = (req.left_col != '0);
			if (!loaded_q) begin
				cmd.kind   = CMD_ERROR;
				cmd.status = STATUS_NOT_LOADED;
			end else if (bad_coord) begin
				cmd.kind   = CMD_ERROR;
				cmd.status = STATUS_BAD_COORD;
			end else begin
				cmd.kind   = CMD_QUERY;
				cmd.status = STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RESET;
			cols_q   <= COLS_RESET;
			row_q    <= '0;
			col_q    <= '0;
			run_q    <= '0;
			loaded_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROWS_IN_USE: rows_q <= clamp_size(cfg_data, ROWS_CAP);
				REG_COLS_IN_USE: cols_q <= clamp_size(cfg_data, COLS_CAP);
				default: ;
			endcase
			row_q    <= '0;
			col_q    <= '0;
			run_q    <= '0;
			loaded_q <= 1'b0;
		end else if (accept && req.op == OP_LOAD) begin
			row_q    <= row_d;
			col_q    <= col_d;
			run_q    <= run_d;
			loaded_q <= loaded_d;
		end
	end

endmodule

// ===== hdl/rsumt_back.sv =====
// Back end: sequences table reads and writes for loads and queries.
module rsumt_back #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_empty,
	input  rsumt_pkg::cmd_t      cmd_head,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output rsumt_pkg::result_t   res_item
);
	import rsumt_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW = RW + CW;

	sum_t          table_mem [2**AW];
	back_state_t   state_q;
	back_state_t   state_d;
	cmd_t          cur_q;
	logic [1:0]    idx_q;
	sum_t          acc_q;
	sum_t          rd_q;
	logic          pend_en_s1;
	logic          pend_neg_s1;

	pos_t          term_row;
	pos_t          term_col;
	logic          term_en;
	logic          term_neg;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	sum_t          wr_data;
	logic          mem_we;

	function automatic logic [AW-1:0] table_addr(pos_t row, pos_t col);
		logic [31:0] r32;
		logic [31:0] c32;
		r32 = 32'(row);
		c32 = 32'(col);
		return {r32[RW-1:0], c32[CW-1:0]};
	endfunction

	// Query terms: bottom-right adds, the left-edge and top-edge terms subtract, the corner adds back.
	always_comb begin
		case (idx_q)
			2'd0: begin
				term_row = cur_q.hi_row;
				term_col = cur_q.hi_col;
				term_en  = 1'b1;
				term_neg = 1'b0;
			end
			2'd1: begin
				term_row = cur_q.hi_row;
				term_col = cur_q.lo_col;
				term_en  = cur_q.use_lo_col;
				term_neg = 1'b1;
			end
			2'd2: begin
				term_row = cur_q.lo_row;
				term_col = cur_q.hi_col;
				term_en  = cur_q.use_lo_row;
				term_neg = 1'b1;
			end
			default: begin
				term_row = cur_q.lo_row;
				term_col = cur_q.lo_col;
				term_en  = cur_q.use_lo_row && cur_q.use_lo_col;
				term_neg = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd_head.kind)
						CMD_LOAD:  state_d = B_LREAD;
						CMD_QUERY: state_d = B_QREAD;
						default:   state_d = B_EMIT;
					endcase
				end
			end
			B_LREAD:  state_d = B_LWRITE;
			B_LWRITE: state_d = B_IDLE;
			B_QREAD: begin
				if (idx_q == 2'd3) begin
					state_d = B_QLAST;
				end
			end
			B_QLAST: state_d = B_EMIT;
			B_EMIT: begin
				if (!res_full) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		mem_we   = 1'b0;
		rd_addr  = table_addr(term_row, term_col);
		wr_addr  = table_addr(cur_q.hi_row, cur_q.hi_col);
		wr_data  = acc_q + (cur_q.use_lo_row ? rd_q : '0);
		case (state_q)
			B_IDLE:   cmd_pop = !cmd_empty;
			B_LREAD:  rd_addr = table_addr(cur_q.lo_row, cur_q.hi_col);
			B_LWRITE: mem_we = 1'b1;
			B_EMIT:   res_push = !res_full;
			default: ;
		endcase
	end

	assign res_item.rect_sum = acc_q;
	assign res_item.status   = cur_q.status;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd_head;
			acc_q <= (cmd_head.kind == CMD_LOAD) ? cmd_head.sum : '0;
			idx_q <= '0;
		end else begin
			if (pend_en_s1) begin
				acc_q <= pend_neg_s1 ? acc_q - rd_q : acc_q + rd_q;
			end
			if (state_q == B_QREAD) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		pend_neg_s1 <= term_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			pend_en_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_en_s1 <= (state_q == B_QREAD) && term_en;
		end
	end

endmodule

// ===== hdl/rectangle_sum_table_unit.sv =====
// Top level of the rectangle sum table unit.
`include "rectangle_sum_table_unit_assert.svh"

// Builds a summed-area table from matrix elements pushed in row-major order and answers
// rectangle sum queries from it. Each pushed item is a load or a query; loads give no
// result, each query gives one result with a status (ok, bad coordinates, or matrix not
// fully loaded). Items are checked and queued by the front end, so pushes are taken while
// the table sequencer works. The table memory has one read and one write port, and the
// sequencer sets the rate: a load needs a read and a write, a valid query four table reads
// plus drain and hand-off, a rejected query only the hand-off. The table is not cleared
// after reset; every entry a query or load uses has been written earlier in the same load
// pass. Writing rows_in_use or cols_in_use restarts loading; write them only while idle.
module rectangle_sum_table_unit #(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLS    = 256,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  rsumt_pkg::request_t               request,
	output logic                              empty,
	input  logic                              pop,
	output rsumt_pkg::result_t                result,
	input  logic                              cfg_write,
	input  logic [rsumt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rsumt_pkg::CFG_W-1:0]       cfg_data
);
	import rsumt_pkg::*;

	cmd_t    front_cmd;
	cmd_t    cmd_head;
	logic    cmd_push;
	logic    cmd_pop;
	logic    cmd_empty;
	logic    res_push;
	logic    res_full;
	result_t res_item;

	// Every accepted item, load or query, turns into one command.
	assign cmd_push = push && !full;

	rsumt_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (cmd_push),
		.req      (request),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (front_cmd)
	);

	rsumt_queue #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(cmd_t)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (full),
		.wr_item(front_cmd),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rd_item(cmd_head)
	);

	rsumt_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_head (cmd_head),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	rsumt_queue #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(result_t)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wr_item(res_item),
		.pop    (pop),
		.empty  (empty),
		.rd_item(result)
	);

	`RSUMT_ASSERT_IMPL(a_res_push_room, clk, arst_n, res_push, !res_full, "result transfer into a full queue")
	`RSUMT_ASSERT_IMPL(a_cmd_pop_valid, clk, arst_n, cmd_pop, !cmd_empty, "command taken from an empty queue")
	`RSUMT_ASSERT_IMPL(a_err_sum_zero, clk, arst_n, res_push && (res_item.status != STATUS_OK), res_item.rect_sum == '0, "rejected query carries a nonzero sum")

endmodule

// ===== dv/rectangle_sum_table_unit_test.sv =====
// Self-checking testbench for the rectangle sum table unit: load and query traffic against a scoreboard.
`timescale 1ns / 1ps

import rsumt_pkg::*;

class rect_sum_board;
	localparam int MAX_SIDE = 256;

	logic [SUM_W-1:0] sat [MAX_SIDE*MAX_SIDE];
	int rows_used;
	int cols_used;
	int next_row;
	int next_col;
	logic [SUM_W-1:0] row_sum;
	bit table_complete;
	result_t pending_answers[$];
	int mismatches;

	function new();
		rows_used = MAX_SIDE;
		cols_used = MAX_SIDE;
		mismatches = 0;
		restart();
	endfunction

	function void restart();
		next_row = 0;
		next_col = 0;
		row_sum = '0;
		table_complete = 1'b0;
	endfunction

	function int clamp(logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	function int slot(int r, int c);
		return r * MAX_SIDE + c;
	endfunction

	function void set_size(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] v);
		if (idx == REG_ROWS_IN_USE)
			rows_used = clamp(v);
		else
			cols_used = clamp(v);
		restart();
	endfunction

	function result_t predict_query(request_t req);
		result_t ans;
		logic [SUM_W-1:0] acc;
		int t, l, b, r;
		t = int'(req.top_row);
		l = int'(req.left_col);
		b = int'(req.bottom_row);
		r = int'(req.right_col);
		ans.rect_sum = '0;
		if (!table_complete) begin
			ans.status = STATUS_NOT_LOADED;
		end else if (t > b || l > r || b >= rows_used || r >= cols_used) begin
			ans.status = STATUS_BAD_COORD;
		end else begin
			// Inclusion-exclusion; terms above row 0 or left of column 0 drop out.
			acc = sat[slot(b, r)];
			if (l > 0)
				acc -= sat[slot(b, l - 1)];
			if (t > 0)
				acc -= sat[slot(t - 1, r)];
			if (t > 0 && l > 0)
				acc += sat[slot(t - 1, l - 1)];
			ans.rect_sum = acc;
			ans.status = STATUS_OK;
		end
		return ans;
	endfunction

	function void accept_request(request_t req);
		logic [SUM_W-1:0] elem;
		logic [SUM_W-1:0] above;
		if (req.op == OP_QUERY) begin
			pending_answers.push_back(predict_query(req));
			return;
		end
		elem = {{(SUM_W-16){req.element_value[15]}}, req.element_value};
		// A load at the origin starts a new matrix.
		if (next_row == 0 && next_col == 0)
			table_complete = 1'b0;
		row_sum = (next_col == 0) ? elem : row_sum + elem;
		above = (next_row > 0) ? sat[slot(next_row - 1, next_col)] : '0;
		sat[slot(next_row, next_col)] = row_sum + above;
		next_col++;
		if (next_col >= cols_used) begin
			next_col = 0;
			next_row++;
			if (next_row >= rows_used) begin
				next_row = 0;
				table_complete = 1'b1;
			end
		end
	endfunction

	task report(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task check_answer(result_t got);
		result_t want;
		if (pending_answers.size() == 0) begin
			report($sformatf("unexpected answer sum %0d status %0d", got.rect_sum, got.status));
			return;
		end
		want = pending_answers.pop_front();
		if (got.status !== want.status)
			report($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.rect_sum !== want.rect_sum)
			report($sformatf("rect_sum got %0d want %0d", got.rect_sum, want.rect_sum));
	endtask
endclass

module rectangle_sum_table_unit_test;
	// Loads still in flight after the last answer need this long to finish.
	localparam int LOAD_DRAIN_CYCLES = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	request_t request = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_ROWS_IN_USE;
	logic [CFG_W-1:0] cfg_data = '0;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;
	int items_sent = 0;
	rect_sum_board board = new();

	rectangle_sum_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic request_t make_load(logic signed [15:0] v);
		request_t it;
		it.op = OP_LOAD;
		it.element_value = v;
		it.top_row = 8'($urandom);
		it.left_col = 8'($urandom);
		it.bottom_row = 8'($urandom);
		it.right_col = 8'($urandom);
		return it;
	endfunction

	function automatic request_t make_query(logic [7:0] t, logic [7:0] l, logic [7:0] b,
			logic [7:0] r);
		request_t it;
		it.op = OP_QUERY;
		it.element_value = 16'($urandom);
		it.top_row = t;
		it.left_col = l;
		it.bottom_row = b;
		it.right_col = r;
		return it;
	endfunction

	function automatic request_t any_query();
		return make_query(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	function automatic request_t valid_query();
		int t, l, b, r;
		t = int'($urandom_range(board.rows_used - 1));
		b = int'($urandom_range(board.rows_used - 1, t));
		l = int'($urandom_range(board.cols_used - 1));
		r = int'($urandom_range(board.cols_used - 1, l));
		return make_query(8'(t), 8'(l), 8'(b), 8'(r));
	endfunction

	function automatic logic signed [15:0] pick_element(int neg_pct);
		int roll;
		roll = int'($urandom_range(99));
		if (roll < neg_pct)
			return -16'sd32768;
		if (roll < neg_pct + (100 - neg_pct) / 3)
			return 16'sd32767;
		return 16'($urandom);
	endfunction

	// Holds push until the transfer; push stays high for a following item.
	task automatic send_request(request_t item);
		request <= item;
		push <= 1'b1;
		do @(posedge clk); while (full);
		board.accept_request(item);
		items_sent++;
	endtask

	task automatic tx_gap();
		if (tx_idle_on && $urandom_range(99) < 29) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (board.pending_answers.size() != 0)
			@(posedge clk);
		repeat (LOAD_DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic resize(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_ROWS_IN_USE;
		cfg_data <= rows_val;
		@(posedge clk);
		board.set_size(REG_ROWS_IN_USE, rows_val);
		cfg_index <= REG_COLS_IN_USE;
		cfg_data <= cols_val;
		@(posedge clk);
		board.set_size(REG_COLS_IN_USE, cols_val);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val,
			int passes, int mid_pct, int neg_pct);
		int cells, remaining, roll;
		resize(rows_val, cols_val);
		cells = board.rows_used * board.cols_used;
		repeat (passes) begin
			// Finish whatever matrix is partly loaded, so queries see a full table.
			remaining = cells - board.next_row * board.cols_used - board.next_col;
			repeat (remaining) begin
				if ($urandom_range(99) < mid_pct) begin
					send_request(any_query());
					tx_gap();
				end
				send_request(make_load(pick_element(neg_pct)));
				tx_gap();
			end
			repeat ($urandom_range(12, 4)) begin
				roll = int'($urandom_range(99));
				if (roll < 3 && cells <= 256)
					send_request(make_load(pick_element(neg_pct)));
				else if (roll < 18)
					send_request(any_query());
				else
					send_request(valid_query());
				tx_gap();
			end
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_answer(result);
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				pop <= rx_idle_on ? ($urandom_range(99) >= 29) : 1'b1;
			end
		end
	end

	initial begin
		int goal;
		int rows_val, cols_val;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing is loaded out of reset.
		send_request(make_query(8'd0, 8'd0, 8'd0, 8'd0));
		resize(9'd2, 9'd3);
		send_request(make_load(16'sd32767));
		send_request(make_load(-16'sd32768));
		send_request(make_load(16'sd0));
		send_request(make_load(-16'sd1));
		send_request(make_load(16'sd32767));
		send_request(make_query(8'd0, 8'd0, 8'd0, 8'd0));
		send_request(make_load(-16'sd32768));
		send_request(make_query(8'd0, 8'd0, 8'd1, 8'd2));
		send_request(make_query(8'd1, 8'd2, 8'd1, 8'd2));
		send_request(make_query(8'd1, 8'd1, 8'd1, 8'd2));
		send_request(make_query(8'd0, 8'd1, 8'd1, 8'd1));
		send_request(make_query(8'd1, 8'd0, 8'd0, 8'd0));
		send_request(make_query(8'd0, 8'd2, 8'd1, 8'd1));
		send_request(make_query(8'd0, 8'd0, 8'd2, 8'd0));
		send_request(make_query(8'd0, 8'd0, 8'd0, 8'd3));
		send_request(make_query(8'd255, 8'd255, 8'd255, 8'd255));
		// A load at the origin begins a reload and hides the old table.
		send_request(make_load(16'sd5));
		send_request(make_query(8'd0, 8'd0, 8'd0, 8'd0));

		// A row count of zero acts as one.
		run_phase(9'd0, 9'd40, 1, 2, 20);
		// The receiver holds off so the block fills and refuses transfers.
		rx_hold = 300;
		repeat (12) send_request(valid_query());
		// A column count of zero acts as one.
		run_phase(9'd6, 9'd0, 1, 2, 20);

		goal = items_sent + 450;
		while (items_sent < goal) begin
			rows_val = int'($urandom_range(8, 1));
			cols_val = int'($urandom_range(8, 1));
			if ($urandom_range(9) == 0)
				rows_val = 0;
			if ($urandom_range(9) == 0)
				cols_val = 0;
			run_phase(9'(rows_val), 9'(cols_val), int'($urandom_range(3, 1)), 6, 20);
		end

		// Oversize column count clamps to the maximum; no idling on either side and
		// mostly extreme elements.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_phase(9'd2, 9'd300, 1, 0, 85);
		send_request(make_query(8'd0, 8'd0, 8'd1, 8'd255));
		send_request(make_query(8'd1, 8'd255, 8'd1, 8'd255));
		send_request(make_query(8'd1, 8'd1, 8'd1, 8'd255));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (20) begin
			send_request(valid_query());
			tx_gap();
		end

		drain();
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("tb: failure");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/rsumt_pkg.sv
hdl/rsumt_queue.sv
hdl/rsumt_front.sv
hdl/rsumt_back.sv
hdl/rectangle_sum_table_unit.sv
dv/rectangle_sum_table_unit_test.sv
